### hdl/assert_macros.svh
// Assertion macros for the checker file of the codec.
// Standalone header: no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CHK_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/gcc_pkg.sv
// Package for the G.711 codec: law and action codes, pipeline stage structs,
// companding constants and the segment priority encoder. No dependencies.
`timescale 1ns / 1ps

package gcc_pkg;

  typedef enum logic {
    LAW_MU = 1'b0,
    LAW_A  = 1'b1
  } law_t;

  typedef enum logic {
    ACT_ENCODE = 1'b0,
    ACT_DECODE = 1'b1
  } action_t;

  localparam logic [14:0] MU_BIAS     = 15'h0084;
  localparam logic [16:0] MU_CLIP     = 17'd32635;
  localparam logic [16:0] A_CLIP      = 17'd31744;
  localparam logic [7:0]  A_MASK      = 8'h55;
  localparam logic [14:0] A_SEG_BASE  = 15'h0108;
  localparam logic [3:0]  A_SEG0_HALF = 4'h8;

  // First stage: sign, clipped (and for mu-law biased) magnitude, unmasked code.
  typedef struct packed {
    logic        valid;
    action_t     action;
    law_t        law;
    logic        neg;
    logic [14:0] val;
    logic [7:0]  dcode;
  } s1_t;

  // Second stage: finished code for encode, sign and magnitude for decode.
  typedef struct packed {
    logic        valid;
    action_t     action;
    logic [7:0]  code;
    logic        neg;
    logic [14:0] mag;
  } s2_t;

  // Index of the highest set bit, 0 when no bit is set.
  function automatic logic [2:0] top_bit8(input logic [7:0] v);
    logic [2:0] e;
    e = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if (v[i]) begin
        e = 3'(i);
      end
    end
    return e;
  endfunction

endpackage

### hdl/g711_companding_codec.sv
// Top level of the G.711 mu-law / A-law codec: law register, two compute
// stages and the output register. Depends on gcc_pkg, gcc_prep, gcc_compand.
`timescale 1ns / 1ps

// Usage:
//   Input: drive action, sample_in and code_in with start high; the item
//   transfers at a rising edge where start is high and busy is low. busy is
//   high only while rst is high, so one item can transfer every clock.
//   action 0 encodes sample_in into code_out, action 1 decodes code_in into
//   sample_out; the unused result field reads zero.
//   Output: done is high for exactly one cycle per item, with code_out and
//   sample_out valid in that cycle; the result transfers at the edge ending
//   it. The receiver has no way to stall, and none is needed.
//   Pipeline: an item passes the two compute stages, then the output register;
//   throughput is one item/clock.
//   Config: cfg_we with cfg_data selects the law (0 mu-law, 1 A-law). Write
//   it only while no item is in flight; each item carries the law it saw.
//   Reset: synchronous rst clears the pipeline valid bits and sets mu-law;
//   items in flight are dropped.
module g711_companding_codec (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [15:0] sample_in,
  input  logic [7:0]  code_in,
  input  logic        cfg_we,
  input  logic        cfg_data,
  output logic        done,
  output logic [7:0]  code_out,
  output logic [15:0] sample_out
);

  gcc_pkg::law_t law;
  gcc_pkg::s1_t  s1;
  gcc_pkg::s2_t  s2;
  logic          accept;
  logic [15:0]   mag16;

  assign busy   = rst;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      law <= gcc_pkg::LAW_MU;
    end else if (cfg_we) begin
      law <= gcc_pkg::law_t'(cfg_data);
    end
  end

  gcc_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .action    (action),
    .sample_in (sample_in),
    .code_in   (code_in),
    .law       (law),
    .s1        (s1)
  );

  gcc_compand u_compand (
    .clk (clk),
    .rst (rst),
    .s1  (s1),
    .s2  (s2)
  );

  assign mag16 = {1'b0, s2.mag};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2.valid;
    end
    if (s2.action == gcc_pkg::ACT_DECODE) begin
      code_out   <= 8'd0;
      sample_out <= s2.neg ? (16'd0 - mag16) : mag16;
    end else begin
      code_out   <= s2.code;
      sample_out <= 16'd0;
    end
  end

endmodule

### hdl/gcc_prep.sv
// First pipeline stage: sign/magnitude split, clipping, mu-law bias and code
// unmasking. Depends on gcc_pkg.
`timescale 1ns / 1ps

module gcc_prep (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               action,
  input  logic [15:0]        sample_in,
  input  logic [7:0]         code_in,
  input  gcc_pkg::law_t      law,
  output gcc_pkg::s1_t       s1
);

  logic        neg;
  logic [16:0] mag;
  logic [14:0] mu_val;
  logic [14:0] a_val;
  gcc_pkg::s1_t s1_next;

  always_comb begin
    neg = sample_in[15];
    mag = neg ? (17'h10000 - {1'b0, sample_in}) : {1'b0, sample_in};
    mu_val = ((mag > gcc_pkg::MU_CLIP) ? gcc_pkg::MU_CLIP[14:0] : mag[14:0])
             + gcc_pkg::MU_BIAS;
    a_val  = (mag > gcc_pkg::A_CLIP) ? gcc_pkg::A_CLIP[14:0] : mag[14:0];

    s1_next.valid  = accept;
    s1_next.action = gcc_pkg::action_t'(action);
    s1_next.law    = law;
    s1_next.neg    = neg;
    if (law == gcc_pkg::LAW_A) begin
      s1_next.val   = a_val;
      s1_next.dcode = code_in ^ gcc_pkg::A_MASK;
    end else begin
      s1_next.val   = mu_val;
      s1_next.dcode = ~code_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1.valid <= s1_next.valid;
    end
    s1.action <= s1_next.action;
    s1.law    <= s1_next.law;
    s1.neg    <= s1_next.neg;
    s1.val    <= s1_next.val;
    s1.dcode  <= s1_next.dcode;
  end

endmodule

### hdl/gcc_compand.sv
// Second pipeline stage: segment search and code assembly for encode,
// segment expansion for decode. Depends on gcc_pkg.
`timescale 1ns / 1ps

module gcc_compand (
  input  logic         clk,
  input  logic         rst,
  input  gcc_pkg::s1_t s1,
  output gcc_pkg::s2_t s2
);

  logic [2:0]  seg;
  logic [14:0] shifted;
  logic [3:0]  mant;
  logic [7:0]  code;
  logic [14:0] mu_t;
  logic [14:0] dmag;
  logic        dneg;
  logic [2:0]  dseg;
  gcc_pkg::s2_t s2_next;

  always_comb begin
    // Encode
    seg     = gcc_pkg::top_bit8(s1.val[14:7]);
    shifted = s1.val >> ({1'b0, seg} + 4'd3);
    mant    = shifted[3:0];
    if (s1.law == gcc_pkg::LAW_A) begin
      // A-law segment 0 spans magnitudes below 256
      if (s1.val[14:8] == 7'd0) begin
        code = {~s1.neg, 3'd0, s1.val[7:4]} ^ gcc_pkg::A_MASK;
      end else begin
        code = {~s1.neg, seg, mant} ^ gcc_pkg::A_MASK;
      end
    end else begin
      code = ~{s1.neg, seg, mant};
    end

    // Decode
    dseg = s1.dcode[6:4];
    mu_t = ({8'd0, s1.dcode[3:0], 3'd0} + gcc_pkg::MU_BIAS) << dseg;
    if (s1.law == gcc_pkg::LAW_A) begin
      dneg = ~s1.dcode[7];
      if (dseg == 3'd0) begin
        dmag = {7'd0, s1.dcode[3:0], gcc_pkg::A_SEG0_HALF};
      end else begin
        dmag = ({7'd0, s1.dcode[3:0], 4'd0} | gcc_pkg::A_SEG_BASE) << (dseg - 3'd1);
      end
    end else begin
      dneg = s1.dcode[7];
      dmag = mu_t - gcc_pkg::MU_BIAS;
    end

    s2_next.valid  = s1.valid;
    s2_next.action = s1.action;
    s2_next.code   = code;
    s2_next.neg    = dneg;
    s2_next.mag    = dmag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else begin
      s2.valid <= s2_next.valid;
    end
    s2.action <= s2_next.action;
    s2.code   <= s2_next.code;
    s2.neg    <= s2_next.neg;
    s2.mag    <= s2_next.mag;
  end

endmodule

### hdl/gcc_checker.sv
// Port-level checker for the G.711 codec, bound to the top level.
// Depends on assert_macros.svh and g711_companding_codec.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gcc_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        action,
  input logic        done,
  input logic [7:0]  code_out,
  input logic [15:0] sample_out
);

  // Every transfer yields a result through the two compute stages and the output register.
  `CHK_NEXT(a_result_follows, clk, rst, start && !busy, ##2 done, "result missing after transfer")
  `CHK_IMPLY(a_no_spurious, clk, rst, done, $past(start && !busy, 3), "result without transfer")
  `CHK_IMPLY(a_decode_code_zero, clk, rst, done && $past(action, 3), code_out == 8'd0, "code_out set on decode")
  `CHK_IMPLY(a_encode_sample_zero, clk, rst, done && !$past(action, 3), sample_out == 16'd0, "sample_out set on encode")

endmodule

bind g711_companding_codec gcc_checker u_gcc_checker (.*);
